// ===== rtl/core/lambda_nfa_subset_construction_acceptor_assert.svh =====
// Assertion macros for the subset construction acceptor.
`ifndef LAMBDA_NFA_SUBSET_CONSTRUCTION_ACCEPTOR_ASSERT_SVH
`define LAMBDA_NFA_SUBSET_CONSTRUCTION_ACCEPTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LNSC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lnsc assertion failed");
`define LNSC_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("lnsc reset check failed");
`else
`define LNSC_ASSERT(label, clk, rstn, prop)
`define LNSC_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/core/lnsc_pkg.sv =====
// Shared types and constants for the subset construction acceptor.
`timescale 1ns / 1ps
package lnsc_pkg;
    localparam logic [7:0] LAMBDA_CHAR = 8'd36;

    typedef enum logic [2:0] {
        ACT_SET_SYMBOL = 3'd0,
        ACT_MARK_ACCEPT = 3'd1,
        ACT_ADD_EDGE = 3'd2,
        ACT_BUILD = 3'd3,
        ACT_FEED = 3'd4,
        ACT_END = 3'd5,
        ACT_NOP6 = 3'd6,
        ACT_NOP7 = 3'd7
    } action_t;

    typedef enum logic [0:0] {
        CFG_NFA_STATES = 1'b0,
        CFG_ALPHABET = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_INIT_CLO,
        ST_CLO,
        ST_SYM_START,
        ST_MOVE,
        ST_UCLO,
        ST_SEARCH,
        ST_NEXT_SYM,
        ST_FEED_RD,
        ST_FEED_WAIT,
        ST_RESULT
    } fsm_t;
endpackage

// ===== rtl/core/lambda_nfa_subset_construction_acceptor.sv =====
// Top level: NFA load, subset construction sequencer and DFA walk.
//
// Use: s_ channel carries one command word per item (load alphabet, mark
// accepting, add transition, build, feed symbol, end string). Each word gives
// exactly one m_ result word. Configuration (NFA states, alphabet size) is
// written on cfg_we / cfg_index / cfg_wdata; the user must write it only while
// idle, which the block does not enforce. Feed and end read the edge memory;
// a character transition reads the move row of each alphabet slot in use and
// writes it back with the target added where the slot holds the char.
// Build: per DFA state and symbol it iterates over NFA states (one per
// cycle), closes the union (one lambda row per cycle until stable) and
// searches the set memory one entry per cycle.
// One item is in work at a time; the next word is taken once the result sits
// in the output register.
// Reset: synchronous, active low; clears masks, lambda rows, counts, walk.
// The move memory is cleared by a sweep of its MAX_NFA_STATES*MAX_SYMBOLS rows
// after reset during which s_tready stays low.
// A stalled receiver holds the result; one more word is taken, but its result
// and any further word wait for m_tready.
`timescale 1ns / 1ps
`include "lambda_nfa_subset_construction_acceptor_assert.svh"
module lambda_nfa_subset_construction_acceptor #(
    parameter int MAX_NFA_STATES = 16,
    parameter int MAX_SYMBOLS = 8,
    parameter int MAX_DFA_STATES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[2:0], position[5:3], from_state[9:6], symbol_char[17:10],
    // to_state[21:18], zero pad [23:22]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // dfa_state[5:0], dfa_state_count[12:6], rejected[13], accepted[14],
    // overflow[15]
    output logic [15:0] m_tdata
);
    import lnsc_pkg::*;

    localparam int N = MAX_NFA_STATES;
    localparam int S = MAX_SYMBOLS;
    localparam int D = MAX_DFA_STATES;
    localparam int NW = (N > 1) ? $clog2(N) : 1;
    localparam int SW = (S > 1) ? $clog2(S) : 1;
    localparam int DW = $clog2(D);
    localparam int MW = $clog2(N * S);
    localparam int EW = $clog2(D * S);

    // configuration
    logic [4:0] nfa_cnt_reg;
    logic [3:0] asz_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nfa_cnt_reg <= 5'd16;
            asz_reg <= 4'd8;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NFA_STATES: nfa_cnt_reg <= cfg_wdata;
                CFG_ALPHABET: asz_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    logic [6:0] n_used;
    logic [6:0] a_used;
    always_comb begin
        if (nfa_cnt_reg == 5'd0) n_used = 7'd1;
        else if (32'(nfa_cnt_reg) > N) n_used = 7'(N);
        else n_used = {2'b00, nfa_cnt_reg};
        if (asz_reg == 4'd0) a_used = 7'd1;
        else if (32'(asz_reg) > S) a_used = 7'(S);
        else a_used = {3'b000, asz_reg};
    end
    logic [N-1:0] use_mask;
    always_comb begin
        for (int i = 0; i < N; i++) use_mask[i] = (7'(i) < n_used);
    end

    // input fields
    logic [2:0] in_action;
    logic [2:0] in_pos;
    logic [3:0] in_from;
    logic [7:0] in_char;
    logic [3:0] in_to;
    assign in_action = s_tdata[2:0];
    assign in_pos = s_tdata[5:3];
    assign in_from = s_tdata[9:6];
    assign in_char = s_tdata[17:10];
    assign in_to = s_tdata[21:18];

    // small register stores
    logic [7:0]   alpha_reg [S];
    logic [N-1:0] acc_mask_reg;
    logic [N-1:0] lam_reg [N];

    // move targets memory: one N-bit row per (state, slot)
    logic [N-1:0] move_mem [N*S];
    logic         mv_we;
    logic [MW-1:0] mv_waddr;
    logic [N-1:0] mv_wdata;
    logic [MW-1:0] mv_raddr;
    logic [N-1:0] mv_rdata;
    always_ff @(posedge aclk) begin
        if (mv_we) move_mem[mv_waddr] <= mv_wdata;
        mv_rdata <= move_mem[mv_raddr];
    end

    // DFA store
    logic          st_we;
    logic [DW-1:0] st_waddr;
    logic [N-1:0]  st_wdata;
    logic          st_wacc;
    logic [DW-1:0] st_raddr;
    logic [N-1:0]  st_rdata;
    logic          st_racc;
    logic          de_we;
    logic [EW-1:0] de_waddr;
    logic [DW:0]   de_wdata;
    logic [EW-1:0] de_raddr;
    logic [DW:0]   de_rdata;

    lnsc_dfa_store #(.NfaStates(N), .DfaStates(D), .Symbols(S)) u_store (
        .aclk(aclk),
        .set_we(st_we), .set_waddr(st_waddr), .set_wdata(st_wdata),
        .set_wacc(st_wacc), .set_raddr(st_raddr), .set_rdata(st_rdata),
        .set_racc(st_racc),
        .edge_we(de_we), .edge_waddr(de_waddr), .edge_wdata(de_wdata),
        .edge_raddr(de_raddr), .edge_rdata(de_rdata)
    );

    // sequencer registers
    fsm_t          state_reg, state_next;
    logic [MW:0]   clr_reg, clr_next;
    logic          clr_done_reg, clr_done_next;
    logic [2:0]    act_reg, act_next;
    logic [7:0]    ch_reg, ch_next;
    logic [NW-1:0] from_reg, from_next;
    logic [NW-1:0] to_reg, to_next;
    logic [SW:0]   slot_reg, slot_next;     // alphabet slot iterator
    logic [DW:0]   built_reg, built_next;
    logic [DW:0]   d_reg, d_next;           // DFA state being expanded
    logic [DW:0]   j_reg, j_next;           // search index
    logic [NW:0]   q_reg, q_next;           // NFA state iterator
    logic [N-1:0]  cur_set_reg, cur_set_next;
    logic [N-1:0]  u_reg, u_next;
    logic          changed_reg, changed_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [DW-1:0] walk_reg, walk_next;
    logic          rej_reg, rej_next;
    logic          ovf_reg, ovf_next;
    logic          res_rej_reg, res_rej_next;
    logic          res_acc_reg, res_acc_next;
    logic          m_valid_reg;
    logic [15:0]   m_data_reg;
    logic          res_load;

    // table write strobes
    logic          alpha_we;
    logic          accm_we;
    logic          lam_we;

    logic [N-1:0] lam_row;
    assign lam_row = (32'(q_reg) < N) ? lam_reg[q_reg[NW-1:0]] : '0;

    // first alphabet slot in use holding the char (feed)
    logic [S-1:0] ch_match;
    always_comb begin
        for (int i = 0; i < S; i++)
            ch_match[i] = (alpha_reg[i] == ch_reg) && (7'(i) < a_used);
    end
    logic [SW-1:0] first_hit;
    always_comb begin
        first_hit = '0;
        for (int i = S - 1; i >= 0; i--) if (ch_match[i]) first_hit = SW'(i);
    end

    assign s_tready = (state_reg == ST_IDLE) && clr_done_reg;
    logic in_fire;
    assign in_fire = s_tvalid && s_tready;

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        clr_done_next = clr_done_reg;
        act_next = act_reg;
        ch_next = ch_reg;
        from_next = from_reg;
        to_next = to_reg;
        slot_next = slot_reg;
        built_next = built_reg;
        d_next = d_reg;
        j_next = j_reg;
        q_next = q_reg;
        cur_set_next = cur_set_reg;
        u_next = u_reg;
        changed_next = changed_reg;
        rd_pend_next = 1'b0;
        walk_next = walk_reg;
        rej_next = rej_reg;
        ovf_next = ovf_reg;
        res_rej_next = res_rej_reg;
        res_acc_next = res_acc_reg;
        res_load = 1'b0;
        alpha_we = 1'b0;
        accm_we = 1'b0;
        lam_we = 1'b0;
        mv_we = 1'b0;
        mv_waddr = '0;
        mv_wdata = '0;
        mv_raddr = '0;
        st_we = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_wacc = 1'b0;
        st_raddr = '0;
        de_we = 1'b0;
        de_waddr = '0;
        de_wdata = '0;
        de_raddr = '0;

        if (!clr_done_reg) begin
            mv_we = 1'b1;
            mv_waddr = clr_reg[MW-1:0];
            clr_next = clr_reg + 1'b1;
            if (32'(clr_reg) == N * S - 1) clr_done_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    act_next = in_action;
                    ch_next = in_char;
                    from_next = NW'(in_from);
                    to_next = NW'(in_to);
                    res_acc_next = 1'b0;
                    unique case (action_t'(in_action))
                        ACT_SET_SYMBOL: begin
                            alpha_we = (32'(in_pos) < S);
                            state_next = ST_RESULT;
                        end
                        ACT_MARK_ACCEPT: begin
                            accm_we = ({3'b000, in_from} < n_used);
                            state_next = ST_RESULT;
                        end
                        ACT_ADD_EDGE: begin
                            if ({3'b000, in_from} < n_used && {3'b000, in_to} < n_used) begin
                                if (in_char == LAMBDA_CHAR) begin
                                    lam_we = 1'b1;
                                    state_next = ST_RESULT;
                                end else begin
                                    slot_next = '0;
                                    state_next = ST_EDGE_RD;
                                end
                            end else begin
                                state_next = ST_RESULT;
                            end
                        end
                        ACT_BUILD: begin
                            ovf_next = 1'b0;
                            cur_set_next = use_mask & N'(1);
                            q_next = '0;
                            changed_next = 1'b0;
                            built_next = '0;
                            state_next = ST_INIT_CLO;
                        end
                        ACT_FEED: state_next = ST_FEED_RD;
                        ACT_END: state_next = ST_FEED_RD;
                        default: state_next = ST_RESULT;
                    endcase
                end
            end
            // read-modify-write of the move row for each matching slot
            ST_EDGE_RD: begin
                if (32'(slot_reg) >= S || {{(6-SW){1'b0}}, slot_reg} >= a_used) begin
                    state_next = ST_RESULT;
                end else begin
                    mv_raddr = MW'(32'(from_reg) * S + 32'(slot_reg));
                    state_next = ST_EDGE_WR;
                end
            end
            ST_EDGE_WR: begin
                if (alpha_reg[slot_reg[SW-1:0]] == ch_reg) begin
                    mv_we = 1'b1;
                    mv_waddr = MW'(32'(from_reg) * S + 32'(slot_reg));
                    mv_wdata = mv_rdata | (N'(1) << to_reg);
                end
                slot_next = slot_reg + 1'b1;
                state_next = ST_EDGE_RD;
            end
            // closure of the start set, one lambda row per cycle
            ST_INIT_CLO: begin
                if (32'(q_reg) < N && {{(6-NW){1'b0}}, q_reg} < n_used) begin
                    if (cur_set_reg[q_reg[NW-1:0]]
                        && ((cur_set_reg | (lam_row & use_mask)) != cur_set_reg)) begin
                        cur_set_next = cur_set_reg | (lam_row & use_mask);
                        changed_next = 1'b1;
                    end
                    q_next = q_reg + 1'b1;
                end else if (changed_reg) begin
                    q_next = '0;
                    changed_next = 1'b0;
                end else begin
                    st_we = 1'b1;
                    st_waddr = '0;
                    st_wdata = cur_set_reg;
                    st_wacc = |(cur_set_reg & acc_mask_reg);
                    built_next = (DW+1)'(1);
                    d_next = '0;
                    state_next = ST_CLO;
                end
            end
            // fetch set of DFA state d
            ST_CLO: begin
                if (d_reg >= built_reg) begin
                    walk_next = '0;
                    rej_next = 1'b0;
                    state_next = ST_RESULT;
                end else begin
                    st_raddr = d_reg[DW-1:0];
                    slot_next = '0;
                    rd_pend_next = 1'b1;
                    state_next = ST_SYM_START;
                end
            end
            ST_SYM_START: begin
                if (rd_pend_reg) cur_set_next = st_rdata;
                if ({{(6-SW){1'b0}}, slot_reg} >= a_used) begin
                    d_next = d_reg + 1'b1;
                    state_next = ST_CLO;
                end else begin
                    u_next = '0;
                    q_next = '0;
                    state_next = ST_MOVE;
                end
            end
            // union of moves: issue read for q, accumulate read of q-1
            ST_MOVE: begin
                if (rd_pend_reg) u_next = u_reg | mv_rdata;
                if (32'(q_reg) < N && {{(6-NW){1'b0}}, q_reg} < n_used) begin
                    if (cur_set_reg[q_reg[NW-1:0]]) begin
                        mv_raddr = MW'(32'(q_reg) * S + 32'(slot_reg));
                        rd_pend_next = 1'b1;
                    end
                    q_next = q_reg + 1'b1;
                end else if (!rd_pend_reg) begin
                    u_next = u_reg & use_mask;
                    q_next = '0;
                    changed_next = 1'b0;
                    state_next = ST_UCLO;
                end
            end
            ST_UCLO: begin
                if (32'(q_reg) < N && {{(6-NW){1'b0}}, q_reg} < n_used) begin
                    if (u_reg[q_reg[NW-1:0]]
                        && ((u_reg | (lam_row & use_mask)) != u_reg)) begin
                        u_next = u_reg | (lam_row & use_mask);
                        changed_next = 1'b1;
                    end
                    q_next = q_reg + 1'b1;
                end else if (changed_reg) begin
                    q_next = '0;
                    changed_next = 1'b0;
                end else if (u_reg == '0) begin
                    state_next = ST_NEXT_SYM;
                end else begin
                    j_next = '0;
                    state_next = ST_SEARCH;
                end
            end
            // search stored sets, one read per cycle, compare one behind
            ST_SEARCH: begin
                if (rd_pend_reg && st_rdata == u_reg) begin
                    de_we = 1'b1;
                    de_waddr = EW'(32'(d_reg) * S + 32'(slot_reg));
                    de_wdata = {1'b1, DW'(j_reg - 1'b1)};
                    state_next = ST_NEXT_SYM;
                end else if (j_reg < built_reg) begin
                    st_raddr = j_reg[DW-1:0];
                    rd_pend_next = 1'b1;
                    j_next = j_reg + 1'b1;
                end else if (!rd_pend_reg || j_reg == built_reg) begin
                    if (32'(built_reg) >= D) begin
                        ovf_next = 1'b1;
                        de_we = 1'b1;
                        de_waddr = EW'(32'(d_reg) * S + 32'(slot_reg));
                        de_wdata = '0;
                    end else begin
                        st_we = 1'b1;
                        st_waddr = built_reg[DW-1:0];
                        st_wdata = u_reg;
                        st_wacc = |(u_reg & acc_mask_reg);
                        de_we = 1'b1;
                        de_waddr = EW'(32'(d_reg) * S + 32'(slot_reg));
                        de_wdata = {1'b1, built_reg[DW-1:0]};
                        built_next = built_reg + 1'b1;
                    end
                    state_next = ST_NEXT_SYM;
                end
            end
            ST_NEXT_SYM: begin
                if (u_reg == '0) begin
                    de_we = 1'b1;
                    de_waddr = EW'(32'(d_reg) * S + 32'(slot_reg));
                    de_wdata = '0;
                end
                slot_next = slot_reg + 1'b1;
                state_next = ST_SYM_START;
            end
            ST_FEED_RD: begin
                de_raddr = EW'(32'(walk_reg) * S + 32'(first_hit));
                st_raddr = walk_reg;
                state_next = ST_FEED_WAIT;
            end
            ST_FEED_WAIT: begin
                if (action_t'(act_reg) == ACT_END) begin
                    res_rej_next = rej_reg;
                    res_acc_next = !rej_reg && built_reg != '0
                                   && {1'b0, walk_reg} < built_reg && st_racc;
                    walk_next = '0;
                    rej_next = 1'b0;
                end else if (!rej_reg) begin
                    if (built_reg == '0 || {1'b0, walk_reg} >= built_reg
                        || ch_match == '0 || !de_rdata[DW]) begin
                        rej_next = 1'b1;
                    end else begin
                        walk_next = de_rdata[DW-1:0];
                    end
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // edge-word writes for missing edges and on overflow leave no valid bit set;
    // the build run writes every (d, slot) it visits, so stale words are
    // replaced before they can be read for d < built.

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
            acc_mask_reg <= '0;
            built_reg <= '0;
            walk_reg <= '0;
            rej_reg <= 1'b0;
            ovf_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < N; i++) lam_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            clr_done_reg <= clr_done_next;
            built_reg <= built_next;
            walk_reg <= walk_next;
            rej_reg <= rej_next;
            ovf_reg <= ovf_next;
            rd_pend_reg <= rd_pend_next;
            if (accm_we) acc_mask_reg[from_next] <= 1'b1;
            if (lam_we) lam_reg[from_next] <= lam_reg[from_next] | (N'(1) << to_next);
            if (res_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg <= act_next;
        ch_reg <= ch_next;
        from_reg <= from_next;
        to_reg <= to_next;
        slot_reg <= slot_next;
        d_reg <= d_next;
        j_reg <= j_next;
        q_reg <= q_next;
        cur_set_reg <= cur_set_next;
        u_reg <= u_next;
        changed_reg <= changed_next;
        res_rej_reg <= res_rej_next;
        res_acc_reg <= res_acc_next;
        if (alpha_we) alpha_reg[in_pos[SW-1:0]] <= in_char;
        if (res_load) begin
            m_data_reg <= {ovf_reg, res_acc_reg,
                           (action_t'(act_reg) == ACT_END) ? res_rej_reg : rej_reg,
                           7'(built_reg), 6'(walk_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    `LNSC_ASSERT(a_one_in_flight, aclk, aresetn, in_fire |=> !s_tready)
    `LNSC_ASSERT(a_hold_stalled, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata))
    `LNSC_ASSERT(a_built_bound, aclk, aresetn, 32'(built_reg) <= D)
    `LNSC_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_IDLE && !m_tvalid))
endmodule

// ===== rtl/core/lnsc_dfa_store.sv =====
// DFA store: set memory, edge memory and accept bits, with registered reads.
`timescale 1ns / 1ps
module lnsc_dfa_store #(
    parameter int NfaStates = 16,
    parameter int DfaStates = 64,
    parameter int Symbols = 8
) (
    input  logic                                      aclk,
    input  logic                                      set_we,
    input  logic [$clog2(DfaStates)-1:0]              set_waddr,
    input  logic [NfaStates-1:0]                      set_wdata,
    input  logic                                      set_wacc,
    input  logic [$clog2(DfaStates)-1:0]              set_raddr,
    output logic [NfaStates-1:0]                      set_rdata,
    output logic                                      set_racc,
    input  logic                                      edge_we,
    input  logic [$clog2(DfaStates*Symbols)-1:0]      edge_waddr,
    input  logic [$clog2(DfaStates):0]                edge_wdata,
    input  logic [$clog2(DfaStates*Symbols)-1:0]      edge_raddr,
    output logic [$clog2(DfaStates):0]                edge_rdata
);
    localparam int DW = $clog2(DfaStates);
    logic [NfaStates-1:0] sets_mem [DfaStates];
    logic                 acc_mem [DfaStates];
    logic [DW:0]          edge_mem [DfaStates*Symbols];

    always_ff @(posedge aclk) begin
        if (set_we) begin
            sets_mem[set_waddr] <= set_wdata;
            acc_mem[set_waddr] <= set_wacc;
        end
        set_rdata <= sets_mem[set_raddr];
        set_racc <= acc_mem[set_raddr];
    end

    // edge word: top bit = valid, low bits = target
    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
        edge_rdata <= edge_mem[edge_raddr];
    end
endmodule
